// ===== src/ebpf_pkg.sv =====
// ----------------------------------------------------------------------------
// eBPF core package
// Shared types, constants and codes of the eBPF instruction execution core.
// ----------------------------------------------------------------------------
package ebpf_pkg;

   localparam int DataBytesDefault  = 4096;
   localparam int StackBytesDefault = 512;
   localparam int NumRegs           = 11;
   localparam int QueueDepth        = 2;

   localparam logic [2:0] REQ_START = 3'd0;
   localparam logic [2:0] REQ_EXEC  = 3'd1;
   localparam logic [2:0] REQ_HWMEM = 3'd2;
   localparam logic [2:0] REQ_HRMEM = 3'd3;
   localparam logic [2:0] REQ_WREG  = 3'd4;
   localparam logic [2:0] REQ_RREG  = 3'd5;

   localparam logic [2:0] ST_CONT   = 3'd0;
   localparam logic [2:0] ST_EXIT   = 3'd1;
   localparam logic [2:0] ST_DIVZ   = 3'd2;
   localparam logic [2:0] ST_BOUNDS = 3'd3;
   localparam logic [2:0] ST_CALL   = 3'd4;
   localparam logic [2:0] ST_HOST   = 3'd5;

   localparam logic [3:0] KIND_START = 4'd0;
   localparam logic [3:0] KIND_ALU   = 4'd1;
   localparam logic [3:0] KIND_DIV   = 4'd2;
   localparam logic [3:0] KIND_SWAP  = 4'd3;
   localparam logic [3:0] KIND_LDDW  = 4'd4;
   localparam logic [3:0] KIND_JUMP  = 4'd5;
   localparam logic [3:0] KIND_CALL  = 4'd6;
   localparam logic [3:0] KIND_EXIT  = 4'd7;
   localparam logic [3:0] KIND_LOAD  = 4'd8;
   localparam logic [3:0] KIND_STORE = 4'd9;
   localparam logic [3:0] KIND_NOP   = 4'd10;
   localparam logic [3:0] KIND_HWMEM = 4'd11;
   localparam logic [3:0] KIND_HRMEM = 4'd12;
   localparam logic [3:0] KIND_WREG  = 4'd13;
   localparam logic [3:0] KIND_RREG  = 4'd14;
   localparam logic [3:0] KIND_HNOP  = 4'd15;

   localparam logic [1:0] CSR_BCE = 2'd0;
   localparam logic [1:0] CSR_PB  = 2'd1;
   localparam logic [1:0] CSR_PL  = 2'd2;

   typedef struct packed {
      logic [2:0]         req_type;
      logic [7:0]         opcode;
      logic [3:0]         dst_reg;
      logic [3:0]         src_reg;
      logic signed [15:0] offset;
      logic signed [31:0] imm;
      logic signed [31:0] next_imm;
      logic [11:0]        host_addr;
      logic [63:0]        host_data;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] next_pc;
      logic [63:0] value;
   } rsp_type;

   typedef struct packed {
      logic [3:0] kind;
      req_type    req;
   } item_type;

endpackage

// ===== src/ebpf_front.sv =====
// ----------------------------------------------------------------------------
// eBPF front end
// Accepts commands, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module ebpf_front
   import ebpf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  req_type  req_item,
   output logic     busy,
   input  logic     pop,
   output logic     q_valid,
   output item_type q_item
);

   localparam int PtrW = $clog2(QueueDepth);

   item_type          q_ff [QueueDepth];
   logic [PtrW-1:0]   wp_ff, wp_in, rp_ff, rp_in;
   logic [PtrW:0]     cnt_ff, cnt_in;
   logic [3:0]        kind;
   logic [7:0]        opc;
   logic              push;

   always_comb begin
      opc = req_item.opcode;
      kind = KIND_HNOP;
      case (req_item.req_type)
         REQ_START: kind = KIND_START;
         REQ_HWMEM: kind = KIND_HWMEM;
         REQ_HRMEM: kind = KIND_HRMEM;
         REQ_WREG:  kind = KIND_WREG;
         REQ_RREG:  kind = KIND_RREG;
         REQ_EXEC: begin
            kind = KIND_NOP;
            if (opc[2:0] == 3'd4 || opc[2:0] == 3'd7) begin
               if (opc[7:4] == 4'hd) kind = (opc[2:0] == 3'd4) ? KIND_SWAP : KIND_NOP;
               else if (opc[7:4] == 4'h3 || opc[7:4] == 4'h9) kind = KIND_DIV;
               else kind = KIND_ALU;
            end else begin
               case (opc)
                  8'h18: kind = KIND_LDDW;
                  8'h85: kind = KIND_CALL;
                  8'h95: kind = KIND_EXIT;
                  8'h61, 8'h69, 8'h71, 8'h79: kind = KIND_LOAD;
                  8'h62, 8'h63, 8'h6a, 8'h6b, 8'h72, 8'h73, 8'h7a, 8'h7b:
                     kind = KIND_STORE;
                  default: if (opc[2:0] == 3'd5) kind = KIND_JUMP;
               endcase
            end
         end
         default: kind = KIND_HNOP;
      endcase
   end

   assign busy    = (cnt_ff == (PtrW+1)'(QueueDepth));
   assign push    = start && !busy;
   assign q_valid = (cnt_ff != '0);
   assign q_item  = q_ff[rp_ff];

   always_comb begin
      wp_in  = push ? PtrW'(wp_ff + 1'b1) : wp_ff;
      rp_in  = pop ? PtrW'(rp_ff + 1'b1) : rp_ff;
      cnt_in = cnt_ff + (PtrW+1)'(push) - (PtrW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) q_ff[wp_ff] <= '{kind: kind, req: req_item};
   end

endmodule

// ===== src/ebpf_div.sv =====
// ----------------------------------------------------------------------------
// eBPF divider
// Radix-2 restoring divider for 64-bit unsigned quotient and remainder.
// ----------------------------------------------------------------------------
module ebpf_div
   import ebpf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  logic [63:0] dividend,
   input  logic [63:0] divisor,
   output logic        done,
   output logic [63:0] quotient,
   output logic [63:0] remainder
);

   logic [63:0] q_ff, q_in, r_ff, r_in, d_ff, d_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in, done_ff, done_in;
   logic [64:0] trial;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      done_in = 1'b0;
      trial = {r_ff, q_ff[63]} - {1'b0, d_ff};
      if (go) begin
         q_in = dividend;
         r_in = '0;
         d_in = divisor;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!trial[64]) begin
            r_in = trial[63:0];
            q_in = {q_ff[62:0], 1'b1};
         end else begin
            r_in = {r_ff[62:0], q_ff[63]};
            q_in = {q_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign done = done_ff;
   assign quotient = q_ff;
   assign remainder = r_ff;

endmodule

// ===== src/ebpf_back.sv =====
// ----------------------------------------------------------------------------
// eBPF back end
// Executes queued items against the register file, pc and data memory.
// ----------------------------------------------------------------------------
module ebpf_back
   import ebpf_pkg::*;
#(
   parameter int DATA_BYTES  = DataBytesDefault,
   parameter int STACK_BYTES = StackBytesDefault
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        bce,
   input  logic [11:0] pbase,
   input  logic [12:0] plen,
   input  logic        q_valid,
   input  item_type    q_item,
   output logic        pop,
   output logic        rsp_valid,
   output rsp_type     rsp
);

   localparam int AW = $clog2(DATA_BYTES);
   localparam logic [63:0] SB = 64'((DATA_BYTES > STACK_BYTES) ?
                                    DATA_BYTES - STACK_BYTES : 0);
   localparam logic [63:0] SL = 64'(DATA_BYTES) - SB;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MEMR = 3'd1;
   localparam logic [2:0] S_MEMW = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_DIVW = 3'd4;
   localparam logic [2:0] S_EXEC = 3'd5;
   localparam logic [2:0] S_MUL  = 3'd6;

   logic [7:0]  mem [DATA_BYTES];
   logic [63:0] rf_ff [NumRegs];
   logic [15:0] pc_ff;
   logic [2:0]  st_ff;
   item_type    cur_ff;
   logic [3:0]  bidx_ff;
   logic [63:0] acc_ff;
   logic [AW-1:0] addr_ff;
   logic [63:0] wdat_ff;
   logic [7:0]  rbyte_ff;
   logic        rd_pend_ff;
   logic        rsp_v_ff;
   rsp_type     rsp_ff;
   logic [1:0]  mstep_ff;
   logic [63:0] macc_ff;

   logic [63:0] d, s, imm64, off64, b, a, r, ea, dd, ds;
   logic [7:0]  opc;
   logic [3:0]  sz;
   logic        ok, taken, w64;
   logic [5:0]  sh;
   logic [15:0] pc1;
   logic        dgo, ddone;
   logic [63:0] dq, dr, dvd, dvs;
   logic [63:0] pr;
   logic [63:0] alu_b, mul_p, mul_sum;
   logic [31:0] mul_x, mul_y;

   function automatic logic [63:0] rd(input logic [63:0] rf [NumRegs],
                                      input logic [3:0] i);
      logic [63:0] v;
      v = '0;
      if (i < 4'(NumRegs)) v = rf[i];
      return v;
   endfunction

   function automatic logic win(input logic [63:0] ad, input logic [63:0] n,
                                input logic [63:0] lo, input logic [63:0] len);
      logic [63:0] dl;
      dl = ad - lo;
      return (ad >= lo) && (dl <= len) && (n <= len - dl);
   endfunction

   always_comb begin
      opc   = cur_ff.req.opcode;
      d     = rd(rf_ff, cur_ff.req.dst_reg);
      s     = rd(rf_ff, cur_ff.req.src_reg);
      imm64 = 64'(signed'(cur_ff.req.imm));
      off64 = 64'(signed'(cur_ff.req.offset));
      w64   = opc[2:0] == 3'd7;
      b     = opc[3] ? s : imm64;
      a     = w64 ? d : {32'd0, d[31:0]};
      if (!w64) b = {32'd0, b[31:0]};
      alu_b = b;
      sh    = w64 ? b[5:0] : {1'b0, b[4:0]};
      pc1   = pc_ff + 16'd1;
      case (opc[7:4])
         4'h0: r = a + b;
         4'h1: r = a - b;
         4'h4: r = a | b;
         4'h5: r = a & b;
         4'h6: r = a << sh;
         4'h7: r = a >> sh;
         4'h8: r = 64'd0 - a;
         4'ha: r = a ^ b;
         4'hb: r = b;
         4'hc: r = w64 ? 64'($signed(a) >>> sh) :
                         64'($signed({{32{a[31]}}, a[31:0]}) >>> sh);
         default: r = a;
      endcase
      if (!w64) r = {32'd0, r[31:0]};
      case (opc[4:3])
         2'b00: sz = 4'd4;
         2'b01: sz = 4'd2;
         2'b10: sz = 4'd1;
         default: sz = 4'd8;
      endcase
      ea = (opc[2:0] == 3'd1 ? s : d) + off64;
      ok = !bce || win(ea, 64'(sz), 64'(pbase), 64'(plen)) || win(ea, 64'(sz), SB, SL);
      dd = d ^ 64'h8000_0000_0000_0000;
      ds = b ^ 64'h8000_0000_0000_0000;
      b  = opc[3] ? s : imm64;
      ds = b ^ 64'h8000_0000_0000_0000;
      case (opc[7:4])
         4'h1: taken = d == b;
         4'h2: taken = d > b;
         4'h3: taken = d >= b;
         4'h4: taken = (d & b) != 0;
         4'h5: taken = d != b;
         4'h6: taken = dd > ds;
         4'h7: taken = dd >= ds;
         4'ha: taken = d < b;
         4'hb: taken = d <= b;
         4'hc: taken = dd < ds;
         4'hd: taken = dd <= ds;
         default: taken = 1'b0;
      endcase
      case (cur_ff.req.imm)
         32'sd16: pr = opc[3] ? {48'd0, d[7:0], d[15:8]} : {48'd0, d[15:0]};
         32'sd32: pr = opc[3] ? {32'd0, d[7:0], d[15:8], d[23:16], d[31:24]} :
                                {32'd0, d[31:0]};
         32'sd64: pr = opc[3] ? {<<8{d}} : d;
         default: pr = d;
      endcase
      dvd = w64 ? d : {32'd0, d[31:0]};
      dvs = opc[3] ? s : imm64;
      if (!w64) dvs = {32'd0, dvs[31:0]};
      mul_x   = (mstep_ff == 2'd2) ? a[63:32] : a[31:0];
      mul_y   = (mstep_ff == 2'd1) ? alu_b[63:32] : alu_b[31:0];
      mul_p   = {32'd0, mul_x} * {32'd0, mul_y};
      mul_sum = macc_ff + {mul_p[31:0], 32'd0};
   end

   assign pop = q_valid && st_ff == S_IDLE;
   assign dgo = st_ff == S_DIV;

   ebpf_div u_div (
      .clock(clock), .reset(reset), .go(dgo), .dividend(dvd), .divisor(dvs),
      .done(ddone), .quotient(dq), .remainder(dr)
   );

   item_type it;
   assign it = q_item;

   always_ff @(posedge clock) begin
      rsp_v_ff <= 1'b0;
      rd_pend_ff <= 1'b0;
      if (rd_pend_ff) acc_ff <= acc_ff | (64'(rbyte_ff) << {bidx_ff - 4'd1, 3'b000});
      case (st_ff)
         S_IDLE: if (q_valid) begin
            cur_ff <= it;
            st_ff <= S_EXEC;
         end
         S_EXEC: begin
            st_ff <= S_IDLE;
            rsp_v_ff <= 1'b1;
            rsp_ff <= '{status: ST_HOST, next_pc: pc_ff, value: 64'd0};
            case (cur_ff.kind)
               KIND_START: begin
                  for (int i = 0; i < NumRegs; i++) rf_ff[i] <= '0;
                  rf_ff[1] <= 64'(pbase);
                  rf_ff[10] <= 64'(DATA_BYTES);
                  pc_ff <= '0;
                  rsp_ff <= '{status: ST_CONT, next_pc: 16'd0, value: 64'd0};
               end
               KIND_ALU: begin
                  if (opc[7:4] == 4'h2) begin
                     rsp_v_ff <= 1'b0;
                     mstep_ff <= 2'd0;
                     st_ff <= S_MUL;
                  end else begin
                     if (!(opc[7:4] == 4'h8 && opc[3]) && opc[7:4] != 4'hd &&
                         opc[7:4] != 4'he && opc[7:4] != 4'hf &&
                         cur_ff.req.dst_reg < 4'(NumRegs))
                        rf_ff[cur_ff.req.dst_reg] <= r;
                     pc_ff <= pc1;
                     rsp_ff <= '{status: ST_CONT, next_pc: pc1, value: 64'd0};
                  end
               end
               KIND_SWAP: begin
                  if (cur_ff.req.dst_reg < 4'(NumRegs)) rf_ff[cur_ff.req.dst_reg] <= pr;
                  pc_ff <= pc1;
                  rsp_ff <= '{status: ST_CONT, next_pc: pc1, value: 64'd0};
               end
               KIND_DIV: begin
                  if (dvs == 64'd0) begin
                     rsp_ff <= '{status: ST_DIVZ, next_pc: pc_ff, value: 64'd0};
                  end else begin
                     rsp_v_ff <= 1'b0;
                     st_ff <= S_DIV;
                  end
               end
               KIND_LDDW: begin
                  if (cur_ff.req.dst_reg < 4'(NumRegs))
                     rf_ff[cur_ff.req.dst_reg] <= {cur_ff.req.next_imm, cur_ff.req.imm};
                  pc_ff <= pc_ff + 16'd2;
                  rsp_ff <= '{status: ST_CONT, next_pc: pc_ff + 16'd2, value: 64'd0};
               end
               KIND_JUMP: begin
                  pc_ff <= (opc == 8'h05 || taken) ? pc1 + off64[15:0] : pc1;
                  rsp_ff <= '{status: ST_CONT,
                              next_pc: (opc == 8'h05 || taken) ? pc1 + off64[15:0] : pc1,
                              value: 64'd0};
               end
               KIND_CALL: begin
                  pc_ff <= pc1;
                  rsp_ff <= '{status: ST_CALL, next_pc: pc1,
                              value: {32'd0, cur_ff.req.imm}};
               end
               KIND_EXIT: rsp_ff <= '{status: ST_EXIT, next_pc: pc_ff, value: rf_ff[0]};
               KIND_LOAD, KIND_STORE: begin
                  if (!ok) begin
                     rsp_ff <= '{status: ST_BOUNDS, next_pc: pc_ff, value: 64'd0};
                  end else begin
                     rsp_v_ff <= 1'b0;
                     addr_ff <= ea[AW-1:0];
                     bidx_ff <= '0;
                     acc_ff <= '0;
                     wdat_ff <= (opc[2:0] == 3'd2) ? imm64 : s;
                     st_ff <= (cur_ff.kind == KIND_LOAD) ? S_MEMR : S_MEMW;
                  end
               end
               KIND_NOP: begin
                  pc_ff <= pc1;
                  rsp_ff <= '{status: ST_CONT, next_pc: pc1, value: 64'd0};
               end
               KIND_HWMEM, KIND_HRMEM: begin
                  rsp_v_ff <= 1'b0;
                  addr_ff <= AW'(cur_ff.req.host_addr);
                  bidx_ff <= '0;
                  acc_ff <= '0;
                  wdat_ff <= cur_ff.req.host_data;
                  st_ff <= (cur_ff.kind == KIND_HRMEM) ? S_MEMR : S_MEMW;
               end
               KIND_WREG:
                  if (cur_ff.req.dst_reg < 4'(NumRegs))
                     rf_ff[cur_ff.req.dst_reg] <= cur_ff.req.host_data;
               KIND_RREG: rsp_ff <= '{status: ST_HOST, next_pc: pc_ff, value: d};
               default: ;
            endcase
         end
         S_MUL: begin
            mstep_ff <= mstep_ff + 2'd1;
            if (mstep_ff == 2'd0) begin
               macc_ff <= mul_p;
            end else if (mstep_ff == 2'd1) begin
               macc_ff <= mul_sum;
            end else begin
               st_ff <= S_IDLE;
               rsp_v_ff <= 1'b1;
               if (cur_ff.req.dst_reg < 4'(NumRegs))
                  rf_ff[cur_ff.req.dst_reg] <= w64 ? mul_sum : {32'd0, mul_sum[31:0]};
               pc_ff <= pc1;
               rsp_ff <= '{status: ST_CONT, next_pc: pc1, value: 64'd0};
            end
         end
         S_MEMR, S_MEMW: begin
            if (bidx_ff == ((cur_ff.kind == KIND_LOAD || cur_ff.kind == KIND_STORE) ?
                            sz : 4'd8)) begin
               if (st_ff == S_MEMR && !rd_pend_ff) begin
                  st_ff <= S_IDLE;
                  rsp_v_ff <= 1'b1;
                  if (cur_ff.kind == KIND_LOAD) begin
                     if (cur_ff.req.dst_reg < 4'(NumRegs)) rf_ff[cur_ff.req.dst_reg] <= acc_ff;
                     pc_ff <= pc1;
                     rsp_ff <= '{status: ST_CONT, next_pc: pc1, value: 64'd0};
                  end else begin
                     rsp_ff <= '{status: ST_HOST, next_pc: pc_ff, value: acc_ff};
                  end
               end else if (st_ff == S_MEMW) begin
                  st_ff <= S_IDLE;
                  rsp_v_ff <= 1'b1;
                  if (cur_ff.kind == KIND_STORE) begin
                     pc_ff <= pc1;
                     rsp_ff <= '{status: ST_CONT, next_pc: pc1, value: 64'd0};
                  end else begin
                     rsp_ff <= '{status: ST_HOST, next_pc: pc_ff, value: 64'd0};
                  end
               end
            end else begin
               if (st_ff == S_MEMR) begin
                  rbyte_ff <= mem[addr_ff];
                  rd_pend_ff <= 1'b1;
               end else begin
                  mem[addr_ff] <= wdat_ff[7:0];
                  wdat_ff <= wdat_ff >> 8;
               end
               addr_ff <= (addr_ff == AW'(DATA_BYTES - 1)) ? '0 : addr_ff + AW'(1);
               bidx_ff <= bidx_ff + 4'd1;
            end
         end
         S_DIV: st_ff <= S_DIVW;
         S_DIVW: if (ddone) begin
            st_ff <= S_IDLE;
            rsp_v_ff <= 1'b1;
            if (cur_ff.req.dst_reg < 4'(NumRegs))
               rf_ff[cur_ff.req.dst_reg] <= w64 ? (opc[7:4] == 4'h3 ? dq : dr) :
                  {32'd0, (opc[7:4] == 4'h3 ? dq[31:0] : dr[31:0])};
            pc_ff <= pc1;
            rsp_ff <= '{status: ST_CONT, next_pc: pc1, value: 64'd0};
         end
         default: st_ff <= S_IDLE;
      endcase
      if (reset) begin
         st_ff <= S_IDLE;
         pc_ff <= '0;
         rsp_v_ff <= 1'b0;
         rd_pend_ff <= 1'b0;
         for (int i = 0; i < NumRegs; i++) rf_ff[i] <= '0;
      end
   end

   assign rsp_valid = rsp_v_ff;
   assign rsp = rsp_ff;

endmodule

// ===== src/ebpf_instruction_execute_core_unit.sv =====
// ----------------------------------------------------------------------------
// eBPF instruction execution core
// Top level: command front end, execution back end and register port.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; a two-entry queue
// lets the host issue while the back end works. Each command returns one
// result, strobed by rsp_valid for one cycle; there is no way to hold a result
// off, so the receiver must take every beat as it comes. Multiply is built
// from three 32-bit partial products; loads, stores and host memory access
// walk the single-port byte memory one byte per cycle; divide and modulo run
// in the radix-2 divider.
module ebpf_instruction_execute_core_unit
   import ebpf_pkg::*;
#(
   parameter int DATA_BYTES  = DataBytesDefault,
   parameter int STACK_BYTES = StackBytesDefault
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_item,
   output logic        rsp_valid,
   output rsp_type     rsp_item,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic        bce_ff;
   logic [11:0] pb_ff;
   logic [12:0] pl_ff;
   logic        pop, q_valid, wr;
   item_type    q_item;

   assign pready = 1'b1;
   assign wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         bce_ff <= 1'b0;
         pb_ff <= '0;
         pl_ff <= '0;
      end else if (wr) begin
         case (paddr[3:2])
            CSR_BCE: bce_ff <= pwdata[0];
            CSR_PB:  pb_ff <= pwdata[11:0];
            CSR_PL:  pl_ff <= pwdata[12:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         CSR_BCE: prdata = {31'd0, bce_ff};
         CSR_PB:  prdata = {20'd0, pb_ff};
         CSR_PL:  prdata = {19'd0, pl_ff};
         default: prdata = '0;
      endcase
   end

   ebpf_front u_front (
      .clock(clock), .reset(reset), .start(start), .req_item(req_item),
      .busy(busy), .pop(pop), .q_valid(q_valid), .q_item(q_item)
   );

   ebpf_back #(.DATA_BYTES(DATA_BYTES), .STACK_BYTES(STACK_BYTES)) u_back (
      .clock(clock), .reset(reset), .bce(bce_ff), .pbase(pb_ff), .plen(pl_ff),
      .q_valid(q_valid), .q_item(q_item), .pop(pop),
      .rsp_valid(rsp_valid), .rsp(rsp_item)
   );

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item.status <= ST_HOST) else $error("bad status");
   a_pop: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_valid) else $error("pop from empty queue");
   a_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("double strobe");

endmodule
